### sv/rbst_pkg.sv
package rbst_pkg;

  localparam int NUM_AXES  = 3;
  localparam int NUM_LANES = 2 * NUM_AXES;
  localparam int NUM_REGS  = 8;

  typedef enum logic [2:0] {
    REG_ORIGIN_X,
    REG_ORIGIN_Y,
    REG_ORIGIN_Z,
    REG_DIR_X,
    REG_DIR_Y,
    REG_DIR_Z,
    REG_T_LOWER,
    REG_T_UPPER
  } reg_idx_e;

  // per-box classification handed from the front to the divider pipe
  typedef struct packed {
    logic [NUM_AXES-1:0]  par;       // direction component is zero
    logic [NUM_AXES-1:0]  dneg;      // direction component is negative
    logic                 par_miss;  // origin outside the slab on a parallel axis
    logic [NUM_LANES-1:0] qneg;      // quotient sign per lane
  } rbst_flags_t;

endpackage

### sv/rbst_front.sv
module rbst_front #(
  parameter int CW = 32
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [CW-1:0]       box_min_i [rbst_pkg::NUM_AXES],
  input  logic [CW-1:0]       box_max_i [rbst_pkg::NUM_AXES],
  input  logic [CW-1:0]       origin_i  [rbst_pkg::NUM_AXES],
  input  logic [CW-1:0]       dir_i     [rbst_pkg::NUM_AXES],
  input  logic                fifo_full_i,
  output logic                out_valid_o,
  output logic [CW:0]         mag_o     [rbst_pkg::NUM_LANES],
  output rbst_pkg::rbst_flags_t flags_o
);
  import rbst_pkg::*;

  logic                valid_q;
  logic                adv;
  logic [CW:0]         mag_d [NUM_LANES];
  logic [CW:0]         mag_q [NUM_LANES];
  rbst_flags_t         flags_d;
  rbst_flags_t         flags_q;

  assign adv         = !valid_q || !fifo_full_i;
  assign in_stall_o  = valid_q && fifo_full_i;
  assign out_valid_o = valid_q;
  assign flags_o     = flags_q;

  always_comb begin
    logic signed [CW:0] dmin;
    logic signed [CW:0] dmax;
    logic signed [CW:0] org;
    flags_d = '0;
    for (int a = 0; a < NUM_AXES; a++) begin
      org  = {origin_i[a][CW-1], origin_i[a]};
      dmin = $signed({box_min_i[a][CW-1], box_min_i[a]}) - org;
      dmax = $signed({box_max_i[a][CW-1], box_max_i[a]}) - org;
      mag_d[a]            = dmin[CW] ? (CW+1)'(-dmin) : dmin;
      mag_d[a+NUM_AXES]   = dmax[CW] ? (CW+1)'(-dmax) : dmax;
      flags_d.qneg[a]          = dmin[CW] ^ dir_i[a][CW-1];
      flags_d.qneg[a+NUM_AXES] = dmax[CW] ^ dir_i[a][CW-1];
      flags_d.par[a]  = (dir_i[a] == '0);
      flags_d.dneg[a] = dir_i[a][CW-1];
      // parallel slab: origin must lie inside, bounds inclusive
      if (flags_d.par[a] && (dmin > 0 || dmax < 0)) begin
        flags_d.par_miss = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (adv) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && in_valid_i) begin
      mag_q   <= mag_d;
      flags_q <= flags_d;
    end
  end

  assign mag_o = mag_q;

endmodule

### sv/rbst_fifo.sv
module rbst_fifo #(
  parameter int W = 8
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         push_i,
  input  logic [W-1:0] data_i,
  output logic         full_o,
  input  logic         pop_i,
  output logic         valid_o,
  output logic [W-1:0] data_o
);

  logic [W-1:0] mem_q [2];
  logic         wr_ptr_q;
  logic         rd_ptr_q;
  logic [1:0]   count_q;

  assign full_o  = (count_q == 2'd2);
  assign valid_o = (count_q != 2'd0);
  assign data_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (pop_i) begin
        rd_ptr_q <= !rd_ptr_q;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 2'd1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

### sv/rbst_back.sv
module rbst_back #(
  parameter int CW = 32,
  parameter int FB = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_pop_o,
  input  logic [CW:0]           mag_i [rbst_pkg::NUM_LANES],
  input  rbst_pkg::rbst_flags_t flags_i,
  input  logic [CW-1:0]         dir_i [rbst_pkg::NUM_AXES],
  input  logic [CW-1:0]         t_lower_i,
  input  logic [CW-1:0]         t_upper_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic                  hit_o
);
  import rbst_pkg::*;

  localparam int QW = CW + 1 + FB;  // quotient bits
  localparam int PW = CW + QW;      // remainder and quotient in one word
  localparam logic [QW-1:0] CapQ = QW'(1) << (CW-1);
  localparam logic [CW-1:0] Cap  = {1'b1, {(CW-1){1'b0}}};

  logic              en;
  logic [CW-1:0]     ud [NUM_AXES];
  logic [PW-1:0]     pr_q [QW+1][NUM_LANES];
  rbst_flags_t       flags_q [QW+1];
  logic              vld_q [QW+1];
  logic [CW-1:0]     t_d [NUM_LANES];
  logic [CW-1:0]     t_q [NUM_LANES];
  rbst_flags_t       fin_flags_q;
  logic              fin_vld_q;
  logic              hit_d;
  logic              out_valid_q;
  logic              hit_q;

  // one restoring step: remainder in the top CW bits, numerator shifts out below
  function automatic logic [PW-1:0] div_step(input logic [PW-1:0] pr,
                                             input logic [CW-1:0] d);
    logic [CW:0] trial;
    logic [CW:0] diff;
    trial = pr[PW-1:QW-1];
    diff  = trial - {1'b0, d};
    if (trial >= {1'b0, d}) begin
      div_step = {diff[CW-1:0], pr[QW-2:0], 1'b1};
    end else begin
      div_step = {pr[PW-2:0], 1'b0};
    end
  endfunction

  assign en          = !out_valid_q || !out_stall_i;
  assign in_pop_o    = en && in_valid_i;
  assign out_valid_o = out_valid_q;
  assign hit_o       = hit_q;

  always_comb begin
    for (int a = 0; a < NUM_AXES; a++) begin
      ud[a] = dir_i[a][CW-1] ? CW'(-dir_i[a]) : dir_i[a];
    end
  end

  // saturate magnitude, apply sign, clamp positive side to the largest value
  always_comb begin
    logic [QW-1:0] q;
    logic [CW-1:0] mag;
    for (int l = 0; l < NUM_LANES; l++) begin
      q   = pr_q[QW][l][QW-1:0];
      mag = (q > CapQ) ? Cap : q[CW-1:0];
      if (flags_q[QW].qneg[l]) begin
        t_d[l] = CW'(-mag);
      end else begin
        t_d[l] = (mag == Cap) ? Cap - CW'(1) : mag;
      end
    end
  end

  always_comb begin
    logic signed [CW-1:0] lo;
    logic signed [CW-1:0] hi;
    logic signed [CW-1:0] ta;
    logic signed [CW-1:0] tb;
    lo = t_lower_i;
    hi = t_upper_i;
    for (int a = 0; a < NUM_AXES; a++) begin
      ta = fin_flags_q.dneg[a] ? t_q[a+NUM_AXES] : t_q[a];
      tb = fin_flags_q.dneg[a] ? t_q[a] : t_q[a+NUM_AXES];
      if (!fin_flags_q.par[a]) begin
        if (ta > lo) begin
          lo = ta;
        end
        if (tb < hi) begin
          hi = tb;
        end
      end
    end
    hit_d = !fin_flags_q.par_miss && (lo <= hi);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s <= QW; s++) begin
        vld_q[s] <= 1'b0;
      end
      fin_vld_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (en) begin
      vld_q[0] <= in_valid_i;
      for (int s = 0; s < QW; s++) begin
        vld_q[s+1] <= vld_q[s];
      end
      fin_vld_q   <= vld_q[QW];
      out_valid_q <= fin_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int l = 0; l < NUM_LANES; l++) begin
        pr_q[0][l] <= {{CW{1'b0}}, mag_i[l], {FB{1'b0}}};
      end
      flags_q[0] <= flags_i;
      for (int s = 0; s < QW; s++) begin
        for (int l = 0; l < NUM_LANES; l++) begin
          pr_q[s+1][l] <= div_step(pr_q[s][l], ud[l % NUM_AXES]);
        end
        flags_q[s+1] <= flags_q[s];
      end
      t_q         <= t_d;
      fin_flags_q <= flags_q[QW];
      hit_q       <= hit_d;
    end
  end

endmodule

### sv/ray_box_slab_test.sv
// box path: classify register, queue, divider stages, t and hit registers; Q16.16 at defaults
// throughput: one box per cycle while out_stall_i is low; the six divider lanes are
// pipelined one quotient bit a stage; a two-entry queue sits between the classify stage
// and the divider pipe; reset clears all valid state and loads the ray registers with their
// defaults (origin 0, direction +x unit, t range [0, largest positive])
module ray_box_slab_test #(
  parameter int COORD_WIDTH = 32,
  parameter int FRAC_BITS   = 16,
  localparam int DataW = (COORD_WIDTH > 32) ? 64 : 32,
  localparam int AddrW = (COORD_WIDTH > 32) ? 6 : 5
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [AddrW-1:0]       paddr,
  input  logic [DataW-1:0]       pwdata,
  output logic [DataW-1:0]       prdata,
  output logic                   pready,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  logic [COORD_WIDTH-1:0] box_min_x_i,
  input  logic [COORD_WIDTH-1:0] box_min_y_i,
  input  logic [COORD_WIDTH-1:0] box_min_z_i,
  input  logic [COORD_WIDTH-1:0] box_max_x_i,
  input  logic [COORD_WIDTH-1:0] box_max_y_i,
  input  logic [COORD_WIDTH-1:0] box_max_z_i,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output logic                   hit_o
);
  import rbst_pkg::*;

  localparam int CW    = COORD_WIDTH;
  localparam int FlagW = $bits(rbst_flags_t);
  localparam int ItemW = NUM_LANES * (CW + 1) + FlagW;

  logic [CW-1:0]    cfg_q [NUM_REGS];
  reg_idx_e         idx;
  logic             wr_en;

  logic [CW-1:0]    box_min [NUM_AXES];
  logic [CW-1:0]    box_max [NUM_AXES];
  logic [CW-1:0]    origin  [NUM_AXES];
  logic [CW-1:0]    dir     [NUM_AXES];

  logic             front_valid;
  logic             fifo_full;
  logic             fifo_valid;
  logic             fifo_pop;
  logic [CW:0]      front_mag [NUM_LANES];
  rbst_flags_t      front_flags;
  logic [ItemW-1:0] fifo_in;
  logic [ItemW-1:0] fifo_out;
  logic [CW:0]      back_mag [NUM_LANES];
  rbst_flags_t      back_flags;

  assign idx    = reg_idx_e'(paddr[AddrW-1 -: 3]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign prdata = DataW'(cfg_q[idx]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int r = 0; r < NUM_REGS; r++) begin
        if (r == REG_DIR_X) begin
          cfg_q[r] <= CW'(1) << FRAC_BITS;
        end else if (r == REG_T_UPPER) begin
          cfg_q[r] <= {1'b0, {(CW-1){1'b1}}};
        end else begin
          cfg_q[r] <= '0;
        end
      end
    end else if (wr_en) begin
      cfg_q[idx] <= pwdata[CW-1:0];
    end
  end

  assign box_min[0] = box_min_x_i;
  assign box_min[1] = box_min_y_i;
  assign box_min[2] = box_min_z_i;
  assign box_max[0] = box_max_x_i;
  assign box_max[1] = box_max_y_i;
  assign box_max[2] = box_max_z_i;
  assign origin[0]  = cfg_q[REG_ORIGIN_X];
  assign origin[1]  = cfg_q[REG_ORIGIN_Y];
  assign origin[2]  = cfg_q[REG_ORIGIN_Z];
  assign dir[0]     = cfg_q[REG_DIR_X];
  assign dir[1]     = cfg_q[REG_DIR_Y];
  assign dir[2]     = cfg_q[REG_DIR_Z];

  rbst_front #(
    .CW(CW)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .box_min_i   (box_min),
    .box_max_i   (box_max),
    .origin_i    (origin),
    .dir_i       (dir),
    .fifo_full_i (fifo_full),
    .out_valid_o (front_valid),
    .mag_o       (front_mag),
    .flags_o     (front_flags)
  );

  always_comb begin
    fifo_in[FlagW-1:0] = front_flags;
    for (int l = 0; l < NUM_LANES; l++) begin
      fifo_in[FlagW + l*(CW+1) +: CW+1] = front_mag[l];
    end
    back_flags = fifo_out[FlagW-1:0];
    for (int l = 0; l < NUM_LANES; l++) begin
      back_mag[l] = fifo_out[FlagW + l*(CW+1) +: CW+1];
    end
  end

  rbst_fifo #(
    .W(ItemW)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (front_valid && !fifo_full),
    .data_i  (fifo_in),
    .full_o  (fifo_full),
    .pop_i   (fifo_pop),
    .valid_o (fifo_valid),
    .data_o  (fifo_out)
  );

  rbst_back #(
    .CW(CW),
    .FB(FRAC_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (fifo_valid),
    .in_pop_o    (fifo_pop),
    .mag_i       (back_mag),
    .flags_i     (back_flags),
    .dir_i       (dir),
    .t_lower_i   (cfg_q[REG_T_LOWER]),
    .t_upper_i   (cfg_q[REG_T_UPPER]),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .hit_o       (hit_o)
  );

endmodule

### bench/ray_box_slab_test_test.sv
`timescale 1ns / 1ps

module ray_box_slab_test_test;
  import rbst_pkg::*;

  localparam int FB = 16;
  localparam int LIMIT = 400000;
  localparam logic signed [31:0] ONE = 32'sd65536;
  localparam logic signed [31:0] SMAX = 32'sh7fffffff;
  localparam logic signed [31:0] SMIN = 32'sh80000000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [4:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic [31:0] box_min_x_i = '0, box_min_y_i = '0, box_min_z_i = '0;
  logic [31:0] box_max_x_i = '0, box_max_y_i = '0, box_max_z_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic hit_o;

  ray_box_slab_test dut (.*);

  always #1 clk_i = ~clk_i;

  logic signed [31:0] ray_reg [8];
  bit hit_queue [$];
  int errors = 0;
  int cycles = 0;
  int hold_off = 0;
  int idle_left = 0;
  bit took = 1'b0;
  bit random_stall = 1'b1;

  typedef struct {
    logic signed [31:0] lo [3];
    logic signed [31:0] hi [3];
  } box_t;

  task automatic report(input string msg);
    $display("mismatch: %s", msg);
    errors++;
  endtask

  // truncated quotient num*2^FB/den, saturated to the signed range
  function automatic longint slab_div(input longint num, input longint den);
    longint q;
    q = (num * (64'sd1 <<< FB)) / den;
    if (q > longint'(SMAX)) q = SMAX;
    if (q < longint'(SMIN)) q = SMIN;
    return q;
  endfunction

  function automatic bit predict_hit(input box_t b);
    longint t_in, t_out, ta, tb, o, d;
    bit miss;
    t_in = ray_reg[REG_T_LOWER];
    t_out = ray_reg[REG_T_UPPER];
    miss = 0;
    for (int ax = 0; ax < 3; ax++) begin
      o = ray_reg[ax];
      d = ray_reg[3 + ax];
      if (d == 0) begin
        if (!(b.lo[ax] <= o && o <= b.hi[ax])) miss = 1;
      end else begin
        ta = slab_div(longint'(b.lo[ax]) - o, d);
        tb = slab_div(longint'(b.hi[ax]) - o, d);
        if (d < 0) begin
          if (tb > t_in) t_in = tb;
          if (ta < t_out) t_out = ta;
        end else begin
          if (ta > t_in) t_in = ta;
          if (tb < t_out) t_out = tb;
        end
      end
    end
    return !miss && t_in <= t_out;
  endfunction

  task automatic write_reg(input reg_idx_e idx, input logic [31:0] val);
    @(negedge clk_i);
    psel <= 1; pwrite <= 1; penable <= 0; paddr <= 5'(4 * idx); pwdata <= val;
    @(negedge clk_i);
    penable <= 1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    psel <= 0; penable <= 0; pwrite <= 0;
    ray_reg[idx] = val;
  endtask

  task automatic drain;
    in_valid_i <= 0;
    while (hit_queue.size() != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
  endtask

  task automatic set_ray(input logic [31:0] v [8]);
    drain();
    for (int i = 0; i < 8; i++) write_reg(reg_idx_e'(i), v[i]);
  endtask

  task automatic send_box(input box_t b, input bit gaps);
    int wait_n;
    wait_n = gaps ? $urandom_range(0, 9) : 0;
    if (wait_n > 0) begin
      in_valid_i <= 0;
      repeat (wait_n) @(negedge clk_i);
    end
    box_min_x_i <= b.lo[0]; box_min_y_i <= b.lo[1]; box_min_z_i <= b.lo[2];
    box_max_x_i <= b.hi[0]; box_max_y_i <= b.hi[1]; box_max_z_i <= b.hi[2];
    in_valid_i <= 1;
    do @(posedge clk_i); while (in_stall_o);
    hit_queue.push_back(predict_hit(b));
    @(negedge clk_i);
  endtask

  function automatic box_t make_box(input logic signed [31:0] a0, a1, a2, b0, b1, b2);
    box_t b;
    b.lo = '{a0, a1, a2};
    b.hi = '{b0, b1, b2};
    return b;
  endfunction

  function automatic logic signed [31:0] rnd_coord();
    case ($urandom_range(0, 5))
      0: return $urandom;
      1: return $urandom_range(0, 3) == 0 ? SMAX : SMIN;
      default: return $signed(32'($urandom_range(0, 20 * 65536))) - 10 * ONE;
    endcase
  endfunction

  function automatic box_t rnd_box();
    box_t b;
    logic signed [31:0] p, q;
    for (int ax = 0; ax < 3; ax++) begin
      p = rnd_coord();
      q = rnd_coord();
      // mostly well-formed boxes, a few inverted ones
      if ($urandom_range(0, 9) != 0 && p > q) begin
        b.lo[ax] = q; b.hi[ax] = p;
      end else begin
        b.lo[ax] = p; b.hi[ax] = q;
      end
    end
    return b;
  endfunction

  task automatic test_directed;
    logic [31:0] r [8];
    r = '{0, 0, 0, ONE, 0, 0, 0, SMAX};
    set_ray(r);
    send_box(make_box(ONE, -ONE, -ONE, 2 * ONE, ONE, ONE), 0);
    send_box(make_box(ONE, ONE, -ONE, 2 * ONE, 2 * ONE, ONE), 0);   // parallel miss
    send_box(make_box(0, 0, 0, 0, 0, 0), 0);                        // touching point
    send_box(make_box(2 * ONE, -ONE, -ONE, ONE, ONE, ONE), 0);      // inverted
    send_box(make_box(-2 * ONE, -ONE, -ONE, -ONE, ONE, ONE), 0);    // behind
    send_box(make_box(SMIN, SMIN, SMIN, SMAX, SMAX, SMAX), 0);
    send_box(make_box(SMAX, 0, 0, SMAX, 0, 0), 0);
    r = '{SMAX, SMIN, ONE, -1, 1, -ONE, SMIN, SMAX};
    set_ray(r);
    send_box(make_box(SMIN, 0, SMIN, SMAX, SMAX, SMAX), 0);
    send_box(make_box(SMIN, SMIN, -ONE, SMAX, SMIN, ONE), 0);
    send_box(make_box(0, -ONE, 0, ONE, ONE, 2 * ONE), 0);
    r = '{0, 0, 0, ONE, ONE, ONE, ONE, 0};                          // reversed interval
    set_ray(r);
    send_box(make_box(SMIN, SMIN, SMIN, SMAX, SMAX, SMAX), 0);
    r = '{SMIN, SMAX, -ONE, SMIN, SMAX, 0, 5 * ONE, 5 * ONE};
    set_ray(r);
    send_box(make_box(SMIN, SMIN, -ONE, SMAX, SMAX, -ONE), 0);
    send_box(make_box(-ONE, ONE, SMIN, ONE, 2 * ONE, SMAX), 0);
  endtask

  task automatic test_random(input int n);
    logic [31:0] r [8];
    for (int i = 0; i < n; i++) begin
      if (i % 75 == 0) begin
        for (int k = 0; k < 8; k++) r[k] = rnd_coord();
        for (int k = 3; k < 6; k++)
          if ($urandom_range(0, 3) == 0) r[k] = 0;
          else if ($urandom_range(0, 2) == 0)
            r[k] = $signed(32'($urandom_range(1, 4 * 65536))) - 2 * ONE;
        r[REG_T_LOWER] = $urandom_range(0, 1) ? SMIN : -ONE;
        r[REG_T_UPPER] = $urandom_range(0, 1) ? SMAX : 100 * ONE;
        set_ray(r);
      end
      send_box(rnd_box(), (i / 40) % 3 != 2);
    end
  endtask

  task automatic test_backpressure;
    random_stall = 0;
    hold_off = 200;
    for (int i = 0; i < 80; i++) send_box(rnd_box(), 0);
    random_stall = 1;
  endtask

  // receiver stall: a randomly drawn wait after each taken result
  always @(negedge clk_i) begin
    if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      out_stall_i <= 1;
    end else if (!random_stall) begin
      out_stall_i <= 0;
    end else if (idle_left > 0) begin
      idle_left <= idle_left - 1;
      out_stall_i <= 1;
    end else begin
      out_stall_i <= 0;
      if (took) idle_left <= $urandom_range(0, 9);
    end
    took = 1'b0;
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      took = 1'b1;
      if (hit_queue.size() == 0) report("hit with no box pending");
      else begin
        bit exp_hit;
        exp_hit = hit_queue.pop_front();
        if (hit_o !== exp_hit) report($sformatf("hit %b expected %b", hit_o, exp_hit));
      end
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("ray_box_slab_test verification failed");
      $finish;
    end
  end

  initial begin
    ray_reg = '{0, 0, 0, ONE, 0, 0, 0, SMAX};
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1;
    test_directed();
    test_backpressure();
    test_random(370);
    drain();
    if (errors == 0) $display("ray_box_slab_test verification clean");
    else $display("ray_box_slab_test verification failed");
    $finish;
  end

endmodule
